// ===== rtl/rtp_stream_continuity_checker_macros.svh =====
// Assertion macros used by the stream checker's port-level assertion module.
`ifndef RTP_STREAM_CONTINUITY_CHECKER_MACROS_SVH
`define RTP_STREAM_CONTINUITY_CHECKER_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define RSCC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stream checker: same-cycle property failed");

// Next-cycle implication, masked while reset is high.
`define RSCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stream checker: next-cycle property failed");

// Next-cycle implication that also holds across reset.
`define RSCC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("stream checker: reset property failed");

`endif

// ===== rtl/rscc_pkg.sv =====
// Types, codes and constants of the RTP stream continuity checker.
`default_nettype none

package rscc_pkg;

   localparam logic       REQ_HEADER = 1'b0;
   localparam logic       REQ_START  = 1'b1;

   localparam logic [1:0] CAUSE_NONE     = 2'd0;
   localparam logic [1:0] CAUSE_ROLLBACK = 2'd1;
   localparam logic [1:0] CAUSE_FOREIGN  = 2'd2;
   localparam logic [1:0] CAUSE_KIND     = 2'd3;

   localparam logic [31:0] TS_WRAP_LOW     = 32'd700000000;
   localparam logic [31:0] TS_WRAP_HIGH    = 32'd800000000;
   localparam logic [31:0] TS_SMALL        = 32'd90000;
   localparam logic [15:0] SEQ_RESET_LIMIT = 16'd5;
   localparam logic [15:0] JUMP_LIMIT      = 16'd4;
   localparam logic [18:0] TICKS_PER_SEQ   = 19'd90000;

   typedef struct packed {
      logic        have_first;
      logic [31:0] learned_source;
      logic [6:0]  learned_kind;
      logic [15:0] expected_seq;
      logic [63:0] last_rx_time;
      logic [31:0] last_timestamp;
   } rscc_state_type;

   typedef struct packed {
      logic        req_type;
      logic [63:0] rx_time;
      logic [31:0] source_id;
      logic [6:0]  payload_kind;
      logic [15:0] seq_number;
      logic [31:0] media_timestamp;
   } rscc_beat_type;

   typedef struct packed {
      logic       accepted;
      logic [1:0] drop_cause;
      logic       data_break;
      logic       time_break;
   } rscc_verdict_type;

   // Timestamp ceiling for a source reset: seq * 90000 for the small sequence numbers.
   function automatic logic [18:0] reset_ceiling(input logic [2:0] seq);
      logic [18:0] ceiling;
      unique case (seq)
         3'd0:    ceiling = 19'd0;
         3'd1:    ceiling = TICKS_PER_SEQ;
         3'd2:    ceiling = 19'(2 * TICKS_PER_SEQ);
         3'd3:    ceiling = 19'(3 * TICKS_PER_SEQ);
         3'd4:    ceiling = 19'(4 * TICKS_PER_SEQ);
         default: ceiling = 19'd0;
      endcase
      return ceiling;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/rscc_judge.sv =====
// Per-header verdict and next learned state of the stream checker.
`default_nettype none

module rscc_judge
   import rscc_pkg::*;
(
   input  wire logic             allow_switch,
   input  wire rscc_state_type   state_now,
   input  wire rscc_beat_type    beat,
   output rscc_state_type        state_next,
   output rscc_verdict_type      verdict
);

   logic        source_differs;
   logic        kind_differs;
   logic        seq_differs;
   logic        source_reset;
   logic        big_jump;
   logic        ts_wrap;
   logic [15:0] seq_delta;

   assign source_differs = state_now.learned_source != beat.source_id;
   assign kind_differs   = state_now.learned_kind != beat.payload_kind;
   assign seq_differs    = state_now.expected_seq != beat.seq_number;
   assign seq_delta      = beat.seq_number - state_now.expected_seq;
   assign big_jump       = seq_delta >= JUMP_LIMIT;
   assign source_reset   = (beat.seq_number < SEQ_RESET_LIMIT) &&
                           (beat.media_timestamp <=
                            {13'd0, reset_ceiling(beat.seq_number[2:0])});
   assign ts_wrap        = (state_now.last_timestamp >= TS_WRAP_LOW) &&
                           (state_now.last_timestamp <= TS_WRAP_HIGH) &&
                           (beat.media_timestamp <= TS_SMALL);

   always_comb begin
      state_next         = state_now;
      verdict.accepted   = 1'b0;
      verdict.drop_cause = CAUSE_NONE;
      verdict.data_break = 1'b0;
      verdict.time_break = 1'b0;

      priority if (beat.req_type == REQ_START) begin
         state_next.have_first = 1'b0;
      end else if (!state_now.have_first) begin
         state_next.have_first     = 1'b1;
         state_next.learned_source = beat.source_id;
         state_next.learned_kind   = beat.payload_kind;
         state_next.expected_seq   = beat.seq_number + 16'd1;
         state_next.last_rx_time   = beat.rx_time;
         state_next.last_timestamp = beat.media_timestamp;
         verdict.accepted          = 1'b1;
      end else if (beat.rx_time < state_now.last_rx_time) begin
         verdict.drop_cause = CAUSE_ROLLBACK;
      end else if (source_differs && !allow_switch) begin
         verdict.drop_cause = CAUSE_FOREIGN;
      end else begin
         // adopt a switched source even if the kind check drops this header
         if (source_differs) begin
            state_next.learned_source = beat.source_id;
         end
         if (kind_differs) begin
            verdict.drop_cause = CAUSE_KIND;
         end else begin
            state_next.expected_seq   = beat.seq_number + 16'd1;
            state_next.last_rx_time   = beat.rx_time;
            state_next.last_timestamp = beat.media_timestamp;
            verdict.accepted          = 1'b1;
            verdict.data_break        = source_differs || seq_differs;
            verdict.time_break        = source_differs || ts_wrap ||
                                        (seq_differs && (source_reset || big_jump));
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rtp_stream_continuity_checker.sv =====
// Top level of the RTP stream continuity checker.
`default_nettype none

// RTP stream continuity checker. Each header beat on the req_ channel yields one
// verdict beat on the rsp_ channel; a session-start beat (req_type = 1) yields
// none and only clears the have_first flag. The block takes one beat per cycle
// while req_stall is low: a beat waits in the input register, is judged by a single pass of
// compares (the 64-bit receive-time compare sets the path), and the verdict
// lands in the result register, which drives rsp_valid. The learned state
// updates at the same edge that a beat leaves the input register, so
// back-to-back headers see each other's effects. A stalled
// verdict holds the result register; the input register keeps accepting while
// the result register is free or draining. Write csr_wr_data (allow source
// switch) only while no beat is in flight.
module rtp_stream_continuity_checker
   import rscc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_type,
   input  wire logic [63:0] req_rx_time,
   input  wire logic [31:0] req_source_id,
   input  wire logic [6:0]  req_payload_kind,
   input  wire logic [15:0] req_seq_number,
   input  wire logic [31:0] req_media_timestamp,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_accepted,
   output logic [1:0]       rsp_drop_cause,
   output logic             rsp_data_break,
   output logic             rsp_time_break,
   output logic [15:0]      rsp_seq_echo
);

   logic             allow_switch_ff;
   rscc_state_type   state_ff;
   rscc_state_type   state_in;
   logic             in_valid_ff;
   rscc_beat_type    in_beat_ff;
   logic             rsp_valid_ff;
   rscc_verdict_type rsp_verdict_ff;
   logic [15:0]      rsp_seq_ff;
   rscc_verdict_type verdict;
   logic             out_free;
   logic             advance;
   logic             load_rsp;
   logic             req_take;

   // Result register can take a verdict when empty or when its beat leaves now.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // Session starts retire without a verdict, so they never wait on the output.
   assign advance   = in_valid_ff && ((in_beat_ff.req_type == REQ_START) || out_free);
   assign load_rsp  = advance && (in_beat_ff.req_type == REQ_HEADER);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   rscc_judge u_judge (
      .allow_switch (allow_switch_ff),
      .state_now    (state_ff),
      .beat         (in_beat_ff),
      .state_next   (state_in),
      .verdict      (verdict)
   );

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         allow_switch_ff <= 1'b0;
      end else if (csr_wr_en) begin
         allow_switch_ff <= csr_wr_data;
      end
   end

   // Learned stream state: commit the judge's next state as a beat retires.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Input register: hold while stalled, refill on every accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_beat_ff.req_type        <= req_type;
         in_beat_ff.rx_time         <= req_rx_time;
         in_beat_ff.source_id       <= req_source_id;
         in_beat_ff.payload_kind    <= req_payload_kind;
         in_beat_ff.seq_number      <= req_seq_number;
         in_beat_ff.media_timestamp <= req_media_timestamp;
      end
   end

   // Result register: load a verdict, drop the valid once the beat is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_verdict_ff <= verdict;
         rsp_seq_ff     <= in_beat_ff.seq_number;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_accepted   = rsp_verdict_ff.accepted;
   assign rsp_drop_cause = rsp_verdict_ff.drop_cause;
   assign rsp_data_break = rsp_verdict_ff.data_break;
   assign rsp_time_break = rsp_verdict_ff.time_break;
   assign rsp_seq_echo   = rsp_seq_ff;

endmodule

`default_nettype wire

// ===== rtl/rscc_checker.sv =====
// Port-level assertions of the stream checker and their bind.
`default_nettype none

`include "rtp_stream_continuity_checker_macros.svh"

module rscc_checker
   import rscc_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        csr_wr_en,
   input wire logic        csr_wr_data,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        req_type,
   input wire logic [63:0] req_rx_time,
   input wire logic [31:0] req_source_id,
   input wire logic [6:0]  req_payload_kind,
   input wire logic [15:0] req_seq_number,
   input wire logic [31:0] req_media_timestamp,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_accepted,
   input wire logic [1:0]  rsp_drop_cause,
   input wire logic        rsp_data_break,
   input wire logic        rsp_time_break,
   input wire logic [15:0] rsp_seq_echo
);

   // a forwarded beat carries no drop cause, a dropped one always has a cause
   `RSCC_ASSERT_IMPLY(a_cause_matches, clock, reset, rsp_valid, rsp_accepted == (rsp_drop_cause == CAUSE_NONE))

   // discontinuity flags ride only on forwarded beats
   `RSCC_ASSERT_IMPLY(a_flags_on_forward, clock, reset, rsp_valid && !rsp_accepted, !rsp_data_break && !rsp_time_break)

   // a stalled verdict holds
   `RSCC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_seq_echo) && $stable(rsp_drop_cause))

   // reset empties the pipeline
   `RSCC_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid && !req_stall)

endmodule

bind rtp_stream_continuity_checker rscc_checker u_rscc_checker (.*);

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the RTP stream continuity checker.

import rscc_pkg::*;

// One verdict beat as it leaves the rsp_ channel.
typedef struct packed {
   rscc_verdict_type verdict;
   logic [15:0]      seq;
} verdict_beat_type;

// Learned stream state, and the verdicts that accepted header beats have earned.
class continuity_board;
   bit               switch_on      = 1'b0;
   bit               have_first     = 1'b0;
   logic [31:0]      learned_source = '0;
   logic [6:0]       learned_kind   = '0;
   logic [15:0]      expected_seq   = '0;
   logic [63:0]      last_rx_time   = '0;
   logic [31:0]      last_timestamp = '0;
   verdict_beat_type pending_verdicts[$];
   int unsigned      errors = 0;

   function void set_switch(bit allow);
      switch_on = allow;
   endfunction

   function void push_verdict(logic ok, logic [1:0] cause, logic db, logic tb,
                              logic [15:0] seq);
      verdict_beat_type v;
      v.verdict = '{accepted: ok, drop_cause: cause, data_break: db, time_break: tb};
      v.seq     = seq;
      pending_verdicts.push_back(v);
   endfunction

   // Judge one accepted input beat.
   function void note_beat(rscc_beat_type b);
      logic        db;
      logic        tb;
      logic [15:0] leap;
      db = 1'b0;
      tb = 1'b0;
      if (b.req_type == REQ_START) begin
         // Forget only the flag; the rest is overwritten by the next first header.
         have_first = 1'b0;
         return;
      end
      if (!have_first) begin
         learned_source = b.source_id;
         learned_kind   = b.payload_kind;
         have_first     = 1'b1;
      end else begin
         if (b.rx_time < last_rx_time) begin
            push_verdict(1'b0, CAUSE_ROLLBACK, 1'b0, 1'b0, b.seq_number);
            return;
         end
         if (b.source_id != learned_source) begin
            if (!switch_on) begin
               push_verdict(1'b0, CAUSE_FOREIGN, 1'b0, 1'b0, b.seq_number);
               return;
            end
            // Adopt the new source before the type check; it sticks even on a drop.
            learned_source = b.source_id;
            db = 1'b1;
            tb = 1'b1;
         end
         if (b.payload_kind != learned_kind) begin
            push_verdict(1'b0, CAUSE_KIND, 1'b0, 1'b0, b.seq_number);
            return;
         end
         if (b.seq_number != expected_seq) begin
            db   = 1'b1;
            leap = b.seq_number - expected_seq;
            if (b.seq_number < SEQ_RESET_LIMIT &&
                b.media_timestamp <= 32'(b.seq_number) * 32'(TICKS_PER_SEQ))
               tb = 1'b1;
            if (leap >= JUMP_LIMIT)
               tb = 1'b1;
         end
         if (last_timestamp >= TS_WRAP_LOW && last_timestamp <= TS_WRAP_HIGH &&
             b.media_timestamp <= TS_SMALL)
            tb = 1'b1;
      end
      expected_seq   = b.seq_number + 16'd1;
      last_rx_time   = b.rx_time;
      last_timestamp = b.media_timestamp;
      push_verdict(1'b1, CAUSE_NONE, db, tb, b.seq_number);
   endfunction

   function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   // Match one delivered verdict against the oldest one pending.
   function void check_verdict(verdict_beat_type got);
      verdict_beat_type want;
      if (pending_verdicts.size() == 0) begin
         $display("%0t: verdict for seq %0d arrived with none pending", $time, got.seq);
         errors++;
         return;
      end
      want = pending_verdicts.pop_front();
      compare_field("accepted",   16'(want.verdict.accepted),   16'(got.verdict.accepted));
      compare_field("drop_cause", 16'(want.verdict.drop_cause), 16'(got.verdict.drop_cause));
      compare_field("data_break", 16'(want.verdict.data_break), 16'(got.verdict.data_break));
      compare_field("time_break", 16'(want.verdict.time_break), 16'(got.verdict.time_break));
      compare_field("seq_echo",   want.seq,                     got.seq);
   endfunction
endclass

module tb;

   localparam int CLOCK_HALF    = 10;
   localparam int RESET_CYCLES  = 12;
   localparam int IDLE_PCT      = 19;
   localparam int HOLD_CYCLES   = 200;
   localparam int SETTLE_CYCLES = 6;
   localparam int PHASE_COUNT   = 6;
   localparam int PHASE_BEATS   = 215;
   localparam int CYCLE_LIMIT   = 400000;

   logic        clock               = 1'b0;
   logic        reset               = 1'b1;
   logic        csr_wr_en           = 1'b0;
   logic        csr_wr_data         = 1'b0;
   logic        req_valid           = 1'b0;
   logic        req_stall;
   logic        req_type            = REQ_HEADER;
   logic [63:0] req_rx_time         = '0;
   logic [31:0] req_source_id       = '0;
   logic [6:0]  req_payload_kind    = '0;
   logic [15:0] req_seq_number      = '0;
   logic [31:0] req_media_timestamp = '0;
   logic        rsp_valid;
   logic        rsp_stall           = 1'b0;
   logic        rsp_accepted;
   logic [1:0]  rsp_drop_cause;
   logic        rsp_data_break;
   logic        rsp_time_break;
   logic [15:0] rsp_seq_echo;

   continuity_board board = new();

   // Idling on both sides; cleared for one whole phase to run flat out.
   bit          gaps_on      = 1'b1;
   // Ask the receiver for its one long hold-off.
   bit          hold_request = 1'b0;
   int unsigned hold_count   = 0;
   int unsigned cycle_count  = 0;
   bit          switch_now   = 1'b0;

   // Stream the stimulus tries to follow, so most headers pass the first checks.
   logic [63:0] gen_rx     = '0;
   logic [31:0] gen_source = '0;
   logic [6:0]  gen_kind   = '0;
   logic [15:0] gen_seq    = '0;
   logic [31:0] gen_ts     = '0;
   bit          wrap_reset_armed = 1'b0;

   rtp_stream_continuity_checker i_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_type            (req_type),
      .req_rx_time         (req_rx_time),
      .req_source_id       (req_source_id),
      .req_payload_kind    (req_payload_kind),
      .req_seq_number      (req_seq_number),
      .req_media_timestamp (req_media_timestamp),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_accepted        (rsp_accepted),
      .rsp_drop_cause      (rsp_drop_cause),
      .rsp_data_break      (rsp_data_break),
      .rsp_time_break      (rsp_time_break),
      .rsp_seq_echo        (rsp_seq_echo)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   // Bail out if the run hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Receiver: check each delivered verdict beat, then pick the next stall.
   // The long hold-off is counted here so the sender keeps pushing meanwhile.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            board.check_verdict(verdict_beat_type'({rsp_accepted, rsp_drop_cause,
                                                    rsp_data_break, rsp_time_break,
                                                    rsp_seq_echo}));
         if (hold_request && hold_count < HOLD_CYCLES) begin
            rsp_stall <= 1'b1;
            hold_count++;
         end else begin
            rsp_stall <= gaps_on && ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // Offer one beat, maybe after idle cycles, and hold it until taken.
   task automatic send_beat(rscc_beat_type b);
      while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_type            <= b.req_type;
      req_rx_time         <= b.rx_time;
      req_source_id       <= b.source_id;
      req_payload_kind    <= b.payload_kind;
      req_seq_number      <= b.seq_number;
      req_media_timestamp <= b.media_timestamp;
      do @(posedge clock); while (req_stall);
      board.note_beat(b);
   endtask

   // Pause the sender until every verdict is in, then let a start beat settle.
   task automatic drain_verdicts();
      req_valid <= 1'b0;
      while (board.pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the source-switch register with the block idle.
   task automatic write_switch(logic allow);
      drain_verdicts();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= allow;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.set_switch(allow);
      switch_now = allow;
   endtask

   function automatic rscc_beat_type header_beat(logic [63:0] rx, logic [31:0] src,
                                                 logic [6:0] kind, logic [15:0] seq,
                                                 logic [31:0] ts);
      rscc_beat_type b;
      b.req_type        = REQ_HEADER;
      b.rx_time         = rx;
      b.source_id       = src;
      b.payload_kind    = kind;
      b.seq_number      = seq;
      b.media_timestamp = ts;
      return b;
   endfunction

   // Session start with junk in the other fields; pick a fresh stream to follow.
   function automatic rscc_beat_type start_beat();
      rscc_beat_type b;
      b.req_type        = REQ_START;
      b.rx_time         = {$urandom, $urandom};
      b.source_id       = $urandom;
      b.payload_kind    = 7'($urandom);
      b.seq_number      = 16'($urandom);
      b.media_timestamp = $urandom;
      gen_source = $urandom;
      gen_kind   = 7'($urandom);
      gen_seq    = 16'($urandom);
      gen_ts     = $urandom;
      return b;
   endfunction

   // Next random beat: mostly the stream continued, then every kind of break,
   // a little noise.
   function automatic rscc_beat_type next_stream_beat();
      rscc_beat_type b;
      int unsigned   pick;
      logic [31:0]   ceiling;
      bit            keep;
      keep = 1'b1;
      pick = $urandom_range(99);
      b = header_beat(gen_rx + 64'($urandom_range(1000)), gen_source, gen_kind, gen_seq,
                      gen_ts + $urandom_range(6000));
      if (wrap_reset_armed) begin
         // Land a small gap just past the sequence wrap, timestamp near the ceiling.
         wrap_reset_armed = 1'b0;
         b.seq_number      = gen_seq + 16'($urandom_range(1, 3));
         ceiling           = 32'(b.seq_number) * 32'(TICKS_PER_SEQ);
         b.media_timestamp = ceiling - 32'($urandom_range(1)) + 32'($urandom_range(1));
      end else if (pick < 60) begin
         // plain continuation
      end else if (pick < 66) begin
         b.seq_number = gen_seq + 16'($urandom_range(1, 3));
      end else if (pick < 70) begin
         b.seq_number = 16'($urandom);
      end else if (pick < 73) begin
         b.seq_number     = 16'hFFFD + 16'($urandom_range(2));
         wrap_reset_armed = 1'b1;
      end else if (pick < 76) begin
         if (gen_rx > 64'd100) begin
            b.rx_time = gen_rx - 64'($urandom_range(1, 100));
            keep      = 1'b0;
         end
      end else if (pick < 79) begin
         b.source_id = $urandom;
         if (switch_now)
            gen_source = b.source_id;
         else
            keep = 1'b0;
      end else if (pick < 82) begin
         b.payload_kind = 7'($urandom);
         keep           = 1'b0;
      end else if (pick < 86) begin
         b.media_timestamp = $urandom_range(TS_WRAP_LOW - 1, TS_WRAP_HIGH + 1);
         if ($urandom_range(3) == 0)
            b.media_timestamp = $urandom_range(1) ? TS_WRAP_LOW : TS_WRAP_HIGH;
      end else if (pick < 90) begin
         b.media_timestamp = $urandom_range(TS_SMALL + 1);
         if ($urandom_range(3) == 0)
            b.media_timestamp = TS_SMALL;
      end else if (pick < 93) begin
         return start_beat();
      end else begin
         b.req_type        = $urandom_range(1) ? REQ_START : REQ_HEADER;
         b.rx_time         = {$urandom, $urandom};
         b.source_id       = $urandom;
         b.payload_kind    = 7'($urandom);
         b.seq_number      = 16'($urandom);
         b.media_timestamp = $urandom;
         return b;
      end
      if (keep) begin
         gen_seq = b.seq_number + 16'd1;
         gen_ts  = b.media_timestamp;
         if (b.rx_time > gen_rx)
            gen_rx = b.rx_time;
      end
      return b;
   endfunction

   initial begin
      int          phase;
      rscc_beat_type b;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_switch(1'b0);

      // Directed: learn a stream at all-zero fields, then walk through every verdict.
      send_beat(header_beat(64'd0, 32'd0, 7'd0, 16'd0, 32'd0));
      send_beat(header_beat(64'd10, 32'd0, 7'd0, 16'd1, 32'd3000));
      send_beat(header_beat(64'd5, 32'd0, 7'd0, 16'd2, 32'd6000));          // rollback
      send_beat(header_beat(64'd20, 32'hFFFF_FFFF, 7'd0, 16'd2, 32'd6000)); // foreign
      send_beat(header_beat(64'd20, 32'd0, 7'h7F, 16'd2, 32'd6000));        // type change
      send_beat(header_beat(64'd20, 32'd0, 7'd0, 16'd3, 32'd9000));         // gap of one
      send_beat(header_beat(64'd30, 32'd0, 7'd0, 16'd100, 32'd12000));      // jump
      send_beat(header_beat(64'd40, 32'd0, 7'd0, 16'hFFFE, 32'd15000));
      // Gap of three across the wrap onto a small sequence: source reset.
      send_beat(header_beat(64'd50, 32'd0, 7'd0, 16'd2, 32'd180000));
      send_beat(header_beat(64'd60, 32'd0, 7'd0, 16'd3, TS_WRAP_LOW));
      send_beat(header_beat(64'd70, 32'd0, 7'd0, 16'd4, TS_SMALL));         // timestamp wrap
      send_beat(header_beat(64'd80, 32'd0, 7'd0, 16'd5, TS_WRAP_HIGH));
      send_beat(header_beat(64'd90, 32'd0, 7'd0, 16'd6, TS_SMALL + 32'd1));
      send_beat(header_beat(64'd100, 32'd0, 7'd0, 16'hFFFE, 32'd20000));
      send_beat(header_beat(64'd110, 32'd0, 7'd0, 16'hFFFF, 32'd23000));
      send_beat(header_beat('1, 32'd0, 7'd0, 16'd0, '1));                  // sequence wrap
      b = '1;
      b.req_type = REQ_START;
      send_beat(b);
      // First header after a start ignores the receive-time rollback.
      send_beat(header_beat(64'd0, '1, 7'h7F, 16'hFFFF, '1));
      send_beat(header_beat(64'd1, '1, 7'h7F, 16'd0, 32'd0));

      write_switch(1'b1);
      send_beat(header_beat(64'd2, 32'h1234_5678, 7'h7F, 16'd1, 32'd3000));  // switch
      send_beat(header_beat(64'd3, 32'h5A5A_A5A5, 7'd0, 16'd2, 32'd6000));   // adopt, drop
      send_beat(header_beat(64'd4, 32'h5A5A_A5A5, 7'h7F, 16'd2, 32'd6000));
      send_beat(start_beat());

      // Random phases: alternate the switch, run one phase flat out, and hold
      // the receiver off in another so the input side backs up.
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         write_switch(phase[0]);
         gaps_on = (phase != 2);
         if (phase == 3)
            hold_request = 1'b1;
         send_beat(start_beat());
         repeat (PHASE_BEATS) send_beat(next_stream_beat());
      end

      drain_verdicts();
      if (board.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
